@@ rtl/core/awlpf_pkg.sv @@
// Shared types, constants and the weight table of the adaptive-weight low-pass filter.
`default_nettype none

package awlpf_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned JumpW   = 31;
  localparam int unsigned CountW  = 10;
  localparam int unsigned StepW   = 3;
  localparam int unsigned WeightW = 16;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned BusW    = 32;

  localparam logic [CountW-1:0] RunInc = CountW'(5);
  localparam logic [CountW-1:0] RunMax = CountW'(1023);
  localparam logic [StepW-1:0]  StepMin = StepW'(1);
  localparam logic [StepW-1:0]  StepMax = StepW'(5);

  localparam logic [JumpW-1:0]  JumpThresholdRst  = JumpW'(65536);
  localparam logic [CountW-1:0] CountThresholdRst = CountW'(10);

  // Register indexes on the configuration port.
  localparam logic RegJumpThreshold  = 1'b0;
  localparam logic RegCountThreshold = 1'b1;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [JumpW-1:0]  jump_threshold;
    logic [CountW-1:0] count_threshold;
  } awlpf_cfg_t;

  // Queue head offered to the back end.
  typedef struct packed {
    logic                    valid;
    logic signed [DataW-1:0] sample;
  } awlpf_item_t;

  // Q0.16 blend weight for a step code; unused codes fold onto the ends.
  function automatic logic [WeightW-1:0] awlpf_weight(input logic [StepW-1:0] step);
    logic [WeightW-1:0] w;
    unique case (step)
      3'd0:    w = 16'd13107;
      3'd1:    w = 16'd13107;
      3'd2:    w = 16'd26214;
      3'd3:    w = 16'd39322;
      3'd4:    w = 16'd52429;
      default: w = 16'd62259;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/awlpf_regs.sv @@
// APB-style configuration registers of the adaptive-weight low-pass filter.
`default_nettype none

module awlpf_regs
  import awlpf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [BusW-1:0]  pwdata,
  output logic      [BusW-1:0]  prdata,
  output logic                  pready,
  output awlpf_cfg_t            cfg_o
);

  logic [JumpW-1:0]  jump_threshold_q;
  logic [CountW-1:0] count_threshold_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write on the access cycle; only the register's own width is kept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_threshold_q  <= JumpThresholdRst;
      count_threshold_q <= CountThresholdRst;
    end else if (wr_en) begin
      unique case (paddr[2])
        RegJumpThreshold:  jump_threshold_q  <= pwdata[JumpW-1:0];
        RegCountThreshold: count_threshold_q <= pwdata[CountW-1:0];
        default:           ;
      endcase
    end
  end

  // Read back the addressed register.
  always_comb begin
    unique case (paddr[2])
      RegJumpThreshold:  prdata = BusW'(jump_threshold_q);
      RegCountThreshold: prdata = BusW'(count_threshold_q);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.jump_threshold  = jump_threshold_q;
  assign cfg_o.count_threshold = count_threshold_q;

endmodule

`default_nettype wire

@@ rtl/core/awlpf_front.sv @@
// Input side: accepts sample beats into a two-entry queue for the back end.
`default_nettype none

module awlpf_front
  import awlpf_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic signed [DataW-1:0] sample_i,
  input  wire logic                    sample_valid_i,
  output logic                         sample_stall_o,
  output awlpf_item_t                  head_o,
  input  wire logic                    pop_i
);

  logic signed [DataW-1:0] mem_q [2];
  logic                    wr_ptr_q, wr_ptr_d;
  logic                    rd_ptr_q, rd_ptr_d;
  logic [1:0]              count_q, count_d;
  logic                    push;
  logic                    pop;

  assign sample_stall_o = (count_q == 2'd2);
  assign push           = sample_valid_i && !sample_stall_o;
  assign pop            = pop_i && (count_q != 2'd0);

  // Advance pointers and fill count.
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold the sample of each accepted beat.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= sample_i;
    end
  end

  assign head_o.valid  = (count_q != 2'd0);
  assign head_o.sample = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

@@ rtl/core/awlpf_back.sv @@
// Back end: direction/run tracking, weight stepping, blend and output register.
`default_nettype none

module awlpf_back
  import awlpf_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire awlpf_cfg_t              cfg_i,
  input  wire awlpf_item_t             head_i,
  output logic                         pop_o,
  output logic signed [DataW-1:0]      filtered_o,
  output logic                         filtered_valid_o,
  input  wire logic                    filtered_stall_i
);

  logic signed [DataW-1:0]   last_q;
  logic                      dir_up_q, dir_up_d;
  logic [CountW-1:0]         run_q, run_d;
  logic [StepW-1:0]          step_q, step_d;
  logic                      out_valid_q;
  logic signed [DataW-1:0]   out_q;

  logic signed [DataW:0]     diff;
  logic [DataW:0]            mag;
  logic                      up;
  logic                      big_jump;
  logic [CountW:0]           run_sum;
  logic [CountW-1:0]         run_inc;
  logic [WeightW-1:0]        weight;
  logic signed [DataW+WeightW+1:0] prod;
  logic signed [DataW+WeightW+1:0] prod_rnd;
  logic signed [DataW-1:0]   result;
  logic                      advance;

  // Take the head when the output register is free or being drained.
  assign advance = head_i.valid && (!out_valid_q || !filtered_stall_i);
  assign pop_o   = advance;

  // Exact 33-bit difference and its magnitude.
  assign diff     = {head_i.sample[DataW-1], head_i.sample} - {last_q[DataW-1], last_q};
  assign up       = !diff[DataW] && (diff != '0);
  assign mag      = diff[DataW] ? (DataW+1)'(-diff) : diff;
  assign big_jump = mag > {2'b00, cfg_i.jump_threshold};

  // Saturating run count increment.
  assign run_sum = {1'b0, run_q} + {1'b0, RunInc};
  assign run_inc = run_sum[CountW] ? RunMax : run_sum[CountW-1:0];

  // Next direction, run count and weight step.
  always_comb begin
    dir_up_d = dir_up_q;
    run_d    = run_q;
    step_d   = step_q;
    if (up == dir_up_q) begin
      if (big_jump) begin
        run_d = run_inc;
      end
      if (run_d >= cfg_i.count_threshold) begin
        step_d = (step_q < StepMax) ? step_q + StepW'(1) : StepMax;
      end
    end else begin
      run_d    = '0;
      step_d   = StepMin;
      dir_up_d = up;
    end
  end

  // Blend: last + round_half_up(diff * w / 2^16).
  assign weight   = awlpf_weight(step_d);
  assign prod     = diff * $signed({1'b0, weight});
  assign prod_rnd = prod + (DataW+WeightW+2)'(32768);
  assign result   = last_q + prod_rnd[DataW+WeightW-1:WeightW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      dir_up_q    <= 1'b0;
      run_q       <= '0;
      step_q      <= StepMin;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        last_q      <= result;
        dir_up_q    <= dir_up_d;
        run_q       <= run_d;
        step_q      <= step_d;
        out_valid_q <= 1'b1;
      end else if (!filtered_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result beat.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign filtered_o       = out_q;
  assign filtered_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/core/adaptive_weight_lowpass_filter_core.sv @@
// Top level of the adaptive-weight first-order low-pass filter.
//
// Sample beats (signed Q16.16) enter on sample_i/sample_valid_i; the block
// raises sample_stall_o when its two-entry input queue is full. Filtered beats
// (signed Q16.16) leave on filtered_o/filtered_valid_o, one per sample, in
// order; the receiver holds them with filtered_stall_i, during which the
// output beat stays put and the queue keeps taking samples until it fills.
// An accepted sample is written into the input queue, then taken into the
// output register. Throughput is one sample per cycle while filtered_stall_i
// is low; it is set by the feedback path from the last output through the
// 33-bit subtract, the 33x17 weight multiply and the final add.
// The APB-style port holds jump_threshold (address 0) and count_threshold
// (address 4); write it only while no sample is in flight.
// Reset clears the queue, the output beat, the last output, the direction,
// the run count and sets the weight step to 0.2 and the registers to
// their defaults (1.0 and 10).
`default_nettype none

module adaptive_weight_lowpass_filter_core
  import awlpf_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [AddrW-1:0]        paddr,
  input  wire logic [BusW-1:0]         pwdata,
  output logic      [BusW-1:0]         prdata,
  output logic                         pready,
  input  wire logic signed [DataW-1:0] sample_i,
  input  wire logic                    sample_valid_i,
  output logic                         sample_stall_o,
  output logic signed [DataW-1:0]      filtered_o,
  output logic                         filtered_valid_o,
  input  wire logic                    filtered_stall_i
);

  awlpf_cfg_t  cfg;
  awlpf_item_t head;
  logic        pop;

  awlpf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  awlpf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_i       (sample_i),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .head_o         (head),
    .pop_i          (pop)
  );

  awlpf_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .head_i           (head),
    .pop_o            (pop),
    .filtered_o       (filtered_o),
    .filtered_valid_o (filtered_valid_o),
    .filtered_stall_i (filtered_stall_i)
  );

endmodule

`default_nettype wire

@@ test/awlpf_checker.sv @@
// Checker for the adaptive-weight low-pass filter: tracks registers, predicts and compares beats.
module awlpf_checker
  import awlpf_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic                    pready,
  input  wire logic [AddrW-1:0]        paddr,
  input  wire logic [BusW-1:0]         pwdata,
  input  wire logic signed [DataW-1:0] sample_i,
  input  wire logic                    sample_valid_i,
  input  wire logic                    sample_stall_o,
  input  wire logic signed [DataW-1:0] filtered_o,
  input  wire logic                    filtered_valid_o,
  input  wire logic                    filtered_stall_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);

  localparam int unsigned ReportLimit = 10;

  // Predicted filter state and register copies
  logic signed [DataW-1:0] prev_out;
  logic                    rising;
  logic [CountW-1:0]       run_len;
  logic [StepW-1:0]        step;
  logic [JumpW-1:0]        jump_limit;
  logic [CountW-1:0]       run_limit;

  logic signed [DataW-1:0] filtered_expect_q [$];
  logic signed [DataW-1:0] oldest;
  int unsigned             fails;

  // Q0.16 blend weight of a step; codes below 1 act as 0.2, above 5 as the clamp
  function automatic longint blend_weight(input logic [StepW-1:0] code);
    longint w;
    if (code <= 3'd1) w = 13107;
    else if (code == 3'd2) w = 26214;
    else if (code == 3'd3) w = 39322;
    else if (code == 3'd4) w = 52429;
    else w = 62259;
    return w;
  endfunction

  // Advance the predicted state by one sample beat and return the filtered value
  function automatic logic signed [DataW-1:0] filter_sample(input logic signed [DataW-1:0] s);
    longint diff;
    longint mag;
    longint w;
    longint acc;
    logic   now_up;
    diff   = longint'(s) - longint'(prev_out);
    now_up = diff > 0;
    mag    = (diff < 0) ? -diff : diff;
    if (now_up == rising) begin
      // count large same-direction jumps, saturating
      if (mag > longint'(jump_limit)) begin
        if (int'(run_len) + int'(RunInc) > int'(RunMax)) run_len = RunMax;
        else run_len = run_len + RunInc;
      end
      if (run_len >= run_limit && step < StepMax) step = step + 3'd1;
    end else begin
      // direction flipped: restart the run at the lowest weight
      run_len = '0;
      step    = StepMin;
      rising  = now_up;
    end
    w   = blend_weight(step);
    acc = longint'(prev_out) * (65536 - w) + longint'(s) * w + 32768;
    // bits 47:16 give the floor of acc / 65536
    prev_out = acc[47:16];
    return prev_out;
  endfunction

  task automatic note_failure(input string msg);
    fails++;
    if (fails <= ReportLimit) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_out   = '0;
      rising     = 1'b0;
      run_len    = '0;
      step       = StepMin;
      jump_limit = JumpThresholdRst;
      run_limit  = CountThresholdRst;
      fails      = 0;
      filtered_expect_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // track register writes, keeping only each register's own width
      if (psel && penable && pwrite && pready) begin
        if (paddr[AddrW-1:2] == RegJumpThreshold) jump_limit = pwdata[JumpW-1:0];
        else if (paddr[AddrW-1:2] == RegCountThreshold) run_limit = pwdata[CountW-1:0];
      end
      // compare an accepted filtered beat with the oldest prediction
      if (filtered_valid_o && !filtered_stall_i) begin
        if (filtered_expect_q.size() == 0) begin
          note_failure($sformatf("filtered beat %0d with none expected", filtered_o));
        end else begin
          oldest = filtered_expect_q.pop_front();
          if (filtered_o !== oldest)
            note_failure($sformatf("filtered mismatch: expected %0d, got %0d",
                                   oldest, filtered_o));
        end
      end
      // predict the result of an accepted sample beat
      if (sample_valid_i && !sample_stall_o) filtered_expect_q.push_back(filter_sample(sample_i));
      fail_count_o <= fails;
      pending_o    <= filtered_expect_q.size();
    end
  end

endmodule

@@ test/testbench.sv @@
// Top of the filter testbench: clock, reset, register writes, sample stimulus and verdict.
module testbench;
  import awlpf_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned LongHold   = 64;
  localparam longint      SampleMax  = 64'sh7FFF_FFFF;
  localparam longint      SampleMin  = -64'sh8000_0000;
  localparam logic [AddrW-1:0] JumpAddr  = {RegJumpThreshold, 2'b00};
  localparam logic [AddrW-1:0] CountAddr = {RegCountThreshold, 2'b00};

  logic                    clk_i            = 1'b0;
  logic                    rst_ni           = 1'b0;
  logic                    psel             = 1'b0;
  logic                    penable          = 1'b0;
  logic                    pwrite           = 1'b0;
  logic [AddrW-1:0]        paddr            = '0;
  logic [BusW-1:0]         pwdata           = '0;
  logic [BusW-1:0]         prdata;
  logic                    pready;
  logic signed [DataW-1:0] sample_i         = '0;
  logic                    sample_valid_i   = 1'b0;
  logic                    sample_stall_o;
  logic signed [DataW-1:0] filtered_o;
  logic                    filtered_valid_o;
  logic                    filtered_stall_i = 1'b0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles  = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  bit          tx_idle       = 1'b1;
  bit          rx_idle       = 1'b1;

  // Walk state of the sample source
  longint cursor    = 0;
  int     run_left  = 0;
  bit     going_up  = 1'b0;

  logic [DataW-1:0] directed_samples [22] = '{
    32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
    32'h8000_0001, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000, 32'h0000_FFFF,
    32'h0000_0001, 32'h8000_0000
  };

  adaptive_weight_lowpass_filter_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .sample_i         (sample_i),
    .sample_valid_i   (sample_valid_i),
    .sample_stall_o   (sample_stall_o),
    .filtered_o       (filtered_o),
    .filtered_valid_o (filtered_valid_o),
    .filtered_stall_i (filtered_stall_i)
  );

  awlpf_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .sample_i         (sample_i),
    .sample_valid_i   (sample_valid_i),
    .sample_stall_o   (sample_stall_o),
    .filtered_o       (filtered_o),
    .filtered_valid_o (filtered_valid_o),
    .filtered_stall_i (filtered_stall_i),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // End the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((sample_valid_i && !sample_stall_o) || (filtered_valid_o && !filtered_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: serve long holds on request, else stall in random bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served++;
        filtered_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        filtered_stall_i <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        filtered_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        filtered_stall_i <= 1'b0;
      end
    end
  end

  // Next sample: mostly directed runs with random step sizes, some noise
  function automatic logic [DataW-1:0] next_sample(input int unsigned step_max,
                                                   input int noise_pct,
                                                   input int run_min,
                                                   input int run_max);
    longint stride;
    if ($urandom_range(0, 99) < noise_pct) begin
      case ($urandom_range(0, 3))
        0: cursor = longint'(int'($urandom()));
        1: cursor = $urandom_range(0, 1) ? SampleMax : SampleMin;
        2: ;  // hold the value
        default: cursor = cursor + ($urandom_range(0, 1) ? 1 : -1);
      endcase
    end else begin
      if (run_left <= 0) begin
        run_left = $urandom_range(run_min, run_max);
        going_up = 1'($urandom_range(0, 1));
      end
      run_left--;
      stride = longint'($urandom_range(0, step_max));
      cursor = going_up ? cursor + stride : cursor - stride;
    end
    // clamp at the ends of the range and turn the run around
    if (cursor > SampleMax) begin
      cursor   = SampleMax;
      going_up = 1'b0;
    end else if (cursor < SampleMin) begin
      cursor   = SampleMin;
      going_up = 1'b1;
    end
    return cursor[DataW-1:0];
  endfunction

  task automatic write_reg(input logic [AddrW-1:0] addr, input logic [BusW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one sample beat, after an optional idle burst, and hold it until taken
  task automatic send_one(input logic [DataW-1:0] value);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      sample_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i       <= value;
    do @(posedge clk_i); while (sample_stall_o);
  endtask

  task automatic send_phase(input int count, input int unsigned step_max, input int noise_pct,
                            input int run_min, input int run_max);
    int k;
    run_left = 0;
    for (k = 0; k < count; k++) send_one(next_sample(step_max, noise_pct, run_min, run_max));
    sample_valid_i <= 1'b0;
  endtask

  // Wait until every predicted beat has arrived and the pipeline is empty
  task automatic wait_idle();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int i;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, equal samples, flips and saturation at reset settings
    for (i = 0; i < 22; i++) send_one(directed_samples[i]);
    sample_valid_i <= 1'b0;
    wait_idle();

    // Zero jump threshold, top count threshold: long runs drive the count to saturation
    write_reg(JumpAddr, 32'd0);
    write_reg(CountAddr, 32'd1023);
    send_phase(300, 3000, 0, 250, 300);
    wait_idle();

    // Out-of-width writes: widest jump threshold, zero count threshold, big swings
    write_reg(JumpAddr, 32'hFFFF_FFFF);
    write_reg(CountAddr, 32'h0000_0000);
    send_phase(250, 32'hFFFF_FFFF, 40, 1, 6);
    wait_idle();

    // Mid settings with one long receiver hold so the input backs up
    write_reg(JumpAddr, $urandom_range(0, 4 * 65536));
    write_reg(CountAddr, $urandom_range(0, 40));
    hold_requests++;
    send_phase(400, 8 * 65536, 10, 1, 40);
    wait_idle();

    write_reg(JumpAddr, $urandom_range(0, 5000));
    write_reg(CountAddr, 32'hFFFF_FC00 | $urandom_range(0, 60));
    send_phase(400, 10000, 5, 5, 60);
    wait_idle();

    // Back to reset values; no idling on either side to the end
    write_reg(JumpAddr, 32'd65536);
    write_reg(CountAddr, 32'd10);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_phase(550, 4 * 65536, 10, 1, 30);
    wait_idle();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
